[sv/rmsr_pkg.sv]
// Shared constants, types and the index helper for the multicast slot ring.
package rmsr_pkg;

  localparam int SLOT_DEPTH  = 16;
  localparam int IDX_W       = $clog2(SLOT_DEPTH);
  localparam int MAX_READERS = 8;
  localparam int RID_W       = $clog2(MAX_READERS);
  localparam int CNT_W       = 4;
  localparam int WORD_W      = 32;
  localparam int SIU_W       = IDX_W + 1;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int STATUS_W    = 2;

  localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(SLOT_DEPTH);
  localparam logic [SIU_W-1:0] SIU_MIN   = SIU_W'(2);

  // Register indexes on the configuration port.
  localparam logic [APB_AW-3:0] REG_SLOTS_IN_USE = '0;

  // Operation codes.
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [SIU_W-1:0] slots_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Following slot, wrapping at the clamped ring size.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                 input logic [SIU_W-1:0] siu);
    logic [SIU_W-1:0] n;
    logic [SIU_W-1:0] sum;
    n = siu;
    if (n < SIU_MIN) n = SIU_MIN;
    if (n > SIU_RESET) n = SIU_RESET;
    sum = {1'b0, idx} + SIU_W'(1);
    if (sum >= n) begin
      next_slot = '0;
    end else begin
      next_slot = sum[IDX_W-1:0];
    end
  endfunction

endpackage

[sv/rmsr_req_if.sv]
// Request channel: operation and its operands with a valid/ready handshake.
interface rmsr_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [rmsr_pkg::RID_W-1:0]      reader_id;
  logic [rmsr_pkg::CNT_W-1:0]      reader_count;
  logic [rmsr_pkg::WORD_W-1:0]     data_in;

  modport source (output valid, output operation, output reader_id,
                  output reader_count, output data_in, input ready);
  modport sink (input valid, input operation, input reader_id,
                input reader_count, input data_in, output ready);
endinterface

[sv/rmsr_rsp_if.sv]
// Response channel: status, read word and slot with a valid/ready handshake.
interface rmsr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rmsr_pkg::STATUS_W-1:0]    status;
  logic [rmsr_pkg::WORD_W-1:0]      data_out;
  logic [rmsr_pkg::IDX_W-1:0]       slot_index;

  modport source (output valid, output status, output data_out,
                  output slot_index, input ready);
  modport sink (input valid, input status, input data_out,
                input slot_index, output ready);
endinterface

[sv/rmsr_cfg.sv]
// APB-style configuration register block for the slot ring.
module rmsr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmsr_pkg::APB_AW-1:0] paddr,
  input  logic [rmsr_pkg::APB_DW-1:0] pwdata,
  output logic [rmsr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output rmsr_pkg::cfg_t              cfg
);

  logic [rmsr_pkg::SIU_W-1:0] slots_in_use;
  logic                       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[rmsr_pkg::APB_AW-1:2] == rmsr_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= rmsr_pkg::SIU_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      slots_in_use <= pwdata[rmsr_pkg::SIU_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = rmsr_pkg::APB_DW'(slots_in_use);
    end
  end

  assign cfg.slots_in_use = slots_in_use;

endmodule

[sv/refcounted_multicast_slot_ring.sv]
// Top level of the reference-counted multicast slot ring.
//
// One writer puts words into a ring of slots, and each of up to eight readers
// gets them back in order. A put stores its word with a count of readers that
// still owe a read; the slot becomes free again once that many gets took it.
// The request channel carries the operation, reader id, reader count and word.
// The response channel returns one response per request: a status (done, full
// or empty), the word read on a successful get and the slot that was used.
//
// Each request has a read and a commit: the accept edge issues the reads of the
// slot word memory and the count memory, and the commit edge applies the update
// and loads the response register. A new request is accepted only after the
// previous one has committed, since each one makes a single read-modify-write
// of the count memory. The response is registered at commit, and a new request
// may be accepted while an earlier response still waits in the output register.
//
// If the receiver stalls, the response register holds; a request that has
// finished its read waits without committing until that register frees up.
// Reset clears the write index, reader indices and count valid bits, so every
// count reads as zero; the word store starts uninitialized. The ring size is
// set through the APB port and should change only when idle.
module refcounted_multicast_slot_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmsr_pkg::APB_AW-1:0] paddr,
  input  logic [rmsr_pkg::APB_DW-1:0] pwdata,
  output logic [rmsr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  rmsr_req_if.sink                    req,
  rmsr_rsp_if.source                  rsp
);

  localparam int IDX_W = rmsr_pkg::IDX_W;
  localparam int CNT_W = rmsr_pkg::CNT_W;

  rmsr_pkg::cfg_t   cfg;
  rmsr_pkg::state_t state;
  rmsr_pkg::state_t state_next;

  // Word store and per-slot counts, both with registered reads.
  logic [rmsr_pkg::WORD_W-1:0] slot_store [rmsr_pkg::SLOT_DEPTH];
  logic [CNT_W-1:0]            pend_mem   [rmsr_pkg::SLOT_DEPTH];
  logic [rmsr_pkg::SLOT_DEPTH-1:0] pend_valid;

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] reader_index [rmsr_pkg::MAX_READERS];

  // Request captured at accept, plus the memory read data.
  logic                        op_q;
  logic [rmsr_pkg::RID_W-1:0]  rid_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [rmsr_pkg::WORD_W-1:0] word_q;
  logic [IDX_W-1:0]            addr_q;
  logic [rmsr_pkg::WORD_W-1:0] store_q;
  logic [CNT_W-1:0]            pend_q;
  logic                        pvalid_q;

  logic             accept;
  logic             commit;
  logic [IDX_W-1:0] get_slot;
  logic [IDX_W-1:0] put_next;
  logic [IDX_W-1:0] pend_raddr;
  logic [CNT_W-1:0] pend_cur;
  logic             put_ok;
  logic             get_ok;

  rmsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req.ready = (state == rmsr_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;

  // A put checks the count of the slot after the write index; a get checks
  // the slot that its reader points at.
  assign get_slot   = reader_index[req.reader_id];
  assign put_next   = rmsr_pkg::next_slot(write_index, cfg.slots_in_use);
  assign pend_raddr = (req.operation == rmsr_pkg::OP_PUT) ? put_next : get_slot;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.operation;
      rid_q    <= req.reader_id;
      cnt_q    <= req.reader_count;
      word_q   <= req.data_in;
      addr_q   <= pend_raddr;
      store_q  <= slot_store[get_slot];
      pend_q   <= pend_mem[pend_raddr];
      pvalid_q <= pend_valid[pend_raddr];
    end
  end

  // A count that was never written since reset reads as zero.
  assign pend_cur = pvalid_q ? pend_q : '0;
  assign put_ok   = (op_q == rmsr_pkg::OP_PUT) && (pend_cur == '0);
  assign get_ok   = (op_q == rmsr_pkg::OP_GET) && (pend_cur != '0) &&
                    (addr_q != write_index);

  // The update commits only when the response register can take the result.
  assign commit = (state == rmsr_pkg::S_EXEC) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      rmsr_pkg::S_IDLE: begin
        if (accept) state_next = rmsr_pkg::S_EXEC;
      end
      rmsr_pkg::S_EXEC: begin
        if (commit) state_next = rmsr_pkg::S_IDLE;
      end
      default: state_next = rmsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && put_ok) begin
      slot_store[write_index] <= word_q;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && put_ok) begin
      pend_mem[write_index] <= cnt_q;
    end else if (commit && get_ok) begin
      pend_mem[addr_q] <= pend_cur - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
    end else if (commit && put_ok) begin
      pend_valid[write_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (commit && put_ok) begin
      write_index <= addr_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rmsr_pkg::MAX_READERS; i++) begin
        reader_index[i] <= '0;
      end
    end else if (commit && get_ok) begin
      reader_index[rid_q] <= rmsr_pkg::next_slot(addr_q, cfg.slots_in_use);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (op_q == rmsr_pkg::OP_PUT) begin
        rsp.status     <= put_ok ? rmsr_pkg::ST_DONE : rmsr_pkg::ST_FULL;
        rsp.data_out   <= '0;
        rsp.slot_index <= write_index;
      end else begin
        rsp.status     <= get_ok ? rmsr_pkg::ST_DONE : rmsr_pkg::ST_EMPTY;
        rsp.data_out   <= get_ok ? store_q : '0;
        rsp.slot_index <= addr_q;
      end
    end
  end

endmodule
